### rtl/point_rotate_about_center_unit_macros.svh
// ----------------------------------------------------------------------------
// point rotation unit: assertion macros
// shared property shorthands for the rotation datapath, sampled on clk and
// quiet while rst is high
// ----------------------------------------------------------------------------
`ifndef POINT_ROTATE_ABOUT_CENTER_UNIT_MACROS_SVH
`define POINT_ROTATE_ABOUT_CENTER_UNIT_MACROS_SVH

// condition in this cycle implies consequence in the same cycle
`define PRC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// condition in this cycle implies consequence in the next cycle
`define PRC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/prc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prc_pkg
// types and fixed constants of the point rotation datapath
// ----------------------------------------------------------------------------
package prc_pkg;

  // phase word: one full turn is 2^32
  localparam int PHASE_W = 32;
  // radian and series values are q30
  localparam int FRAC_W = 30;
  // series terms, up to 1.0 in q30
  localparam int TERM_W = 31;
  // running series sums
  localparam int SUM_W = 32;
  // terms after the first one in each series
  localparam int SERIES_TERMS = 6;

  typedef logic [TERM_W-1:0]        term_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic [FRAC_W-1:0]        q30_t;
  typedef logic [1:0]               quad_t;

  localparam q30_t              EIGHTH_TURN  = 30'h2000_0000;
  localparam logic [FRAC_W:0]   QUARTER_TURN = 31'h4000_0000;
  localparam term_t             Q30_ONE      = 31'h4000_0000;
  // pi/2 in q32 is 2^32 plus this
  localparam logic [31:0]       HALF_PI_LOW  = 32'h921F_B544;

  localparam quad_t QUAD_0 = 2'd0;
  localparam quad_t QUAD_1 = 2'd1;
  localparam quad_t QUAD_2 = 2'd2;
  localparam quad_t QUAD_3 = 2'd3;

endpackage

### rtl/prc_angle_prep.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prc_angle_prep
// folds the angle into the first octant and forms x and x^2 in q30 radians
// ----------------------------------------------------------------------------
module prc_angle_prep import prc_pkg::*; #(
  parameter int ANGLE_WIDTH = 16,
  parameter int SIDE_W      = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic [ANGLE_WIDTH-1:0] angle,
  input  logic [SIDE_W-1:0]      side_in,
  output logic                   out_valid,
  output q30_t                   x,
  output q30_t                   x2,
  output quad_t                  quad,
  output logic                   swap,
  output logic [SIDE_W-1:0]      side_out
);

  logic [PHASE_W-1:0] phase;
  q30_t               frac;
  q30_t               frac_fold;
  logic               fold;
  logic [61:0]        prod_k;
  q30_t               x_val;
  logic [59:0]        prod_sq;

  logic               s1_valid, s2_valid;
  q30_t               s1_frac, s2_x;
  quad_t              s1_quad, s2_quad;
  logic               s1_swap, s2_swap;
  logic [SIDE_W-1:0]  s1_side, s2_side;

  assign phase     = PHASE_W'(angle) << (PHASE_W - ANGLE_WIDTH);
  assign frac      = phase[FRAC_W-1:0];
  assign fold      = frac > EIGHTH_TURN;
  assign frac_fold = fold ? FRAC_W'(QUARTER_TURN - {1'b0, frac}) : frac;

  // f * (2^32 + low) >> 32 == f + (f * low >> 32)
  assign prod_k  = 62'(s1_frac) * 62'(HALF_PI_LOW);
  assign x_val   = s1_frac + FRAC_W'(prod_k >> 32);
  assign prod_sq = 60'(s2_x) * 60'(s2_x);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      s1_valid  <= in_valid;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_frac  <= frac_fold;
      s1_quad  <= phase[PHASE_W-1 -: 2];
      s1_swap  <= fold;
      s1_side  <= side_in;
      s2_x     <= x_val;
      s2_quad  <= s1_quad;
      s2_swap  <= s1_swap;
      s2_side  <= s1_side;
      x        <= s2_x;
      x2       <= prod_sq[2*FRAC_W-1:FRAC_W];
      quad     <= s2_quad;
      swap     <= s2_swap;
      side_out <= s2_side;
    end
  end

endmodule

### rtl/prc_series_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prc_series_cell
// one taylor step for sine and cosine: adds (or, with NEG, subtracts) the
// incoming term to each sum and forms the next term as term * x^2 / divisor
// ----------------------------------------------------------------------------
module prc_series_cell import prc_pkg::*; #(
  parameter int DIV_S  = 6,
  parameter int DIV_C  = 2,
  parameter bit NEG    = 1'b0,
  parameter int SIDE_W = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  q30_t              x2_in,
  input  term_t             term_s_in,
  input  term_t             term_c_in,
  input  sum_t              sum_s_in,
  input  sum_t              sum_c_in,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  output q30_t              x2_out,
  output term_t             term_s_out,
  output term_t             term_c_out,
  output sum_t              sum_s_out,
  output sum_t              sum_c_out,
  output logic [SIDE_W-1:0] side_out
);

  // ceiling reciprocal, exact floor division for any 31-bit dividend
  localparam int          SH_S  = TERM_W + $clog2(DIV_S);
  localparam int          SH_C  = TERM_W + $clog2(DIV_C);
  localparam logic [31:0] MUL_S = 32'(((64'd1 << SH_S) + 64'(DIV_S) - 64'd1) / 64'(DIV_S));
  localparam logic [31:0] MUL_C = 32'(((64'd1 << SH_C) + 64'(DIV_C) - 64'd1) / 64'(DIV_C));
  localparam int          PW    = TERM_W + FRAC_W;
  localparam int          RW    = TERM_W + 32;

  logic               a_valid;
  q30_t               a_x2;
  logic [PW-1:0]      a_prod_s, a_prod_c;
  sum_t               a_sum_s, a_sum_c;
  logic [SIDE_W-1:0]  a_side;

  sum_t               sum_s_upd, sum_c_upd;
  logic [RW-1:0]      recip_s, recip_c;

  assign sum_s_upd = NEG ? (sum_s_in - $signed(SUM_W'(term_s_in)))
                         : (sum_s_in + $signed(SUM_W'(term_s_in)));
  assign sum_c_upd = NEG ? (sum_c_in - $signed(SUM_W'(term_c_in)))
                         : (sum_c_in + $signed(SUM_W'(term_c_in)));

  assign recip_s = RW'(a_prod_s[FRAC_W +: TERM_W]) * RW'(MUL_S);
  assign recip_c = RW'(a_prod_c[FRAC_W +: TERM_W]) * RW'(MUL_C);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      a_valid   <= in_valid;
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_x2       <= x2_in;
      a_prod_s   <= PW'(term_s_in) * PW'(x2_in);
      a_prod_c   <= PW'(term_c_in) * PW'(x2_in);
      a_sum_s    <= sum_s_upd;
      a_sum_c    <= sum_c_upd;
      a_side     <= side_in;
      x2_out     <= a_x2;
      term_s_out <= TERM_W'(recip_s >> SH_S);
      term_c_out <= TERM_W'(recip_c >> SH_C);
      sum_s_out  <= a_sum_s;
      sum_c_out  <= a_sum_c;
      side_out   <= a_side;
    end
  end

endmodule

### rtl/prc_rotate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prc_rotate
// rounds sine and cosine, restores the quadrant, rotates the offset about the
// center, then truncates toward zero and saturates
// ----------------------------------------------------------------------------
module prc_rotate import prc_pkg::*; #(
  parameter int COORD_WIDTH    = 16,
  parameter int TRIG_FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  sum_t                          sum_s,
  input  sum_t                          sum_c,
  input  term_t                         term_s,
  input  term_t                         term_c,
  input  quad_t                         quad,
  input  logic                          swap,
  input  logic signed [COORD_WIDTH-1:0] px,
  input  logic signed [COORD_WIDTH-1:0] py,
  input  logic signed [COORD_WIDTH-1:0] cx,
  input  logic signed [COORD_WIDTH-1:0] cy,
  output logic                          out_valid,
  output logic signed [COORD_WIDTH-1:0] rotated_x,
  output logic signed [COORD_WIDTH-1:0] rotated_y,
  output logic                          clipped
);

  localparam int RSH = FRAC_W - TRIG_FRAC_BITS;
  localparam int MW  = TRIG_FRAC_BITS + 1;      // rounded magnitude
  localparam int CSW = TRIG_FRAC_BITS + 2;      // signed sine / cosine
  localparam int DW  = COORD_WIDTH + 1;         // center offset
  localparam int PW  = DW + CSW;                // one product
  localparam int SW  = PW + 1;                  // rotation sum
  localparam int TRW = SW - TRIG_FRAC_BITS;     // after truncation

  localparam logic signed [SUM_W:0] RND  = (SUM_W+1)'(1) <<< (RSH - 1);
  localparam logic signed [SW-1:0]  BIAS = (SW'(1) <<< TRIG_FRAC_BITS) - SW'(1);
  localparam logic signed [TRW-1:0] CMAX =
    TRW'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
  localparam logic signed [TRW-1:0] CMIN = -CMAX - TRW'(1);

  // stage 1: last series term, center offsets
  logic                          r1_valid;
  sum_t                          r1_sin, r1_cos;
  quad_t                         r1_quad;
  logic                          r1_swap;
  logic signed [DW-1:0]          r1_dx, r1_dy;
  logic signed [COORD_WIDTH-1:0] r1_cx, r1_cy;

  // stage 2: signed sine and cosine
  logic                          r2_valid;
  logic signed [CSW-1:0]         r2_sin, r2_cos;
  logic signed [DW-1:0]          r2_dx, r2_dy;
  logic signed [COORD_WIDTH-1:0] r2_cx, r2_cy;

  // stage 3: products
  logic                          r3_valid;
  logic signed [PW-1:0]          r3_xc, r3_ys, r3_xs, r3_yc;
  logic signed [COORD_WIDTH-1:0] r3_cx, r3_cy;

  // stage 4: sums
  logic                          r4_valid;
  logic signed [SW-1:0]          r4_tx, r4_ty;

  logic signed [SUM_W:0]         sin_rnd, cos_rnd;
  logic [MW-1:0]                 sin_mag, cos_mag, mag_s, mag_c;
  logic signed [CSW-1:0]         sp, cp, sin_q, cos_q;
  logic signed [SW-1:0]          cx_sc, cy_sc;
  logic signed [TRW-1:0]         tq_x, tq_y;
  logic                          clip_x, clip_y;

  assign sin_rnd = {r1_sin[SUM_W-1], r1_sin} + RND;
  assign cos_rnd = {r1_cos[SUM_W-1], r1_cos} + RND;
  assign sin_mag = r1_sin[SUM_W-1] ? '0 : MW'(sin_rnd >>> RSH);
  assign cos_mag = r1_cos[SUM_W-1] ? '0 : MW'(cos_rnd >>> RSH);

  // octant fold swaps the pair
  assign mag_s = r1_swap ? cos_mag : sin_mag;
  assign mag_c = r1_swap ? sin_mag : cos_mag;
  assign sp    = $signed({1'b0, mag_s});
  assign cp    = $signed({1'b0, mag_c});

  always_comb begin
    case (r1_quad)
      QUAD_0: begin
        sin_q = sp;
        cos_q = cp;
      end
      QUAD_1: begin
        sin_q = cp;
        cos_q = -sp;
      end
      QUAD_2: begin
        sin_q = -sp;
        cos_q = -cp;
      end
      QUAD_3: begin
        sin_q = -cp;
        cos_q = sp;
      end
      default: begin
        sin_q = sp;
        cos_q = cp;
      end
    endcase
  end

  assign cx_sc = SW'(r3_cx) <<< TRIG_FRAC_BITS;
  assign cy_sc = SW'(r3_cy) <<< TRIG_FRAC_BITS;

  // truncate toward zero
  assign tq_x = r4_tx[SW-1] ? TRW'((r4_tx + BIAS) >>> TRIG_FRAC_BITS)
                            : TRW'(r4_tx >>> TRIG_FRAC_BITS);
  assign tq_y = r4_ty[SW-1] ? TRW'((r4_ty + BIAS) >>> TRIG_FRAC_BITS)
                            : TRW'(r4_ty >>> TRIG_FRAC_BITS);
  assign clip_x = (tq_x > CMAX) || (tq_x < CMIN);
  assign clip_y = (tq_y > CMAX) || (tq_y < CMIN);

  always_ff @(posedge clk) begin
    if (rst) begin
      r1_valid  <= 1'b0;
      r2_valid  <= 1'b0;
      r3_valid  <= 1'b0;
      r4_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      r1_valid  <= in_valid;
      r2_valid  <= r1_valid;
      r3_valid  <= r2_valid;
      r4_valid  <= r3_valid;
      out_valid <= r4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r1_sin  <= sum_s + $signed(SUM_W'(term_s));
      r1_cos  <= sum_c + $signed(SUM_W'(term_c));
      r1_quad <= quad;
      r1_swap <= swap;
      r1_dx   <= DW'(px) - DW'(cx);
      r1_dy   <= DW'(py) - DW'(cy);
      r1_cx   <= cx;
      r1_cy   <= cy;

      r2_sin  <= sin_q;
      r2_cos  <= cos_q;
      r2_dx   <= r1_dx;
      r2_dy   <= r1_dy;
      r2_cx   <= r1_cx;
      r2_cy   <= r1_cy;

      r3_xc   <= PW'(r2_dx) * PW'(r2_cos);
      r3_ys   <= PW'(r2_dy) * PW'(r2_sin);
      r3_xs   <= PW'(r2_dx) * PW'(r2_sin);
      r3_yc   <= PW'(r2_dy) * PW'(r2_cos);
      r3_cx   <= r2_cx;
      r3_cy   <= r2_cy;

      r4_tx   <= SW'(r3_xc) - SW'(r3_ys) + cx_sc;
      r4_ty   <= SW'(r3_xs) + SW'(r3_yc) + cy_sc;

      rotated_x <= (tq_x > CMAX) ? COORD_WIDTH'(CMAX) :
                   (tq_x < CMIN) ? COORD_WIDTH'(CMIN) : COORD_WIDTH'(tq_x);
      rotated_y <= (tq_y > CMAX) ? COORD_WIDTH'(CMAX) :
                   (tq_y < CMIN) ? COORD_WIDTH'(CMIN) : COORD_WIDTH'(tq_y);
      clipped   <= clip_x || clip_y;
    end
  end

endmodule

### rtl/point_rotate_about_center_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_rotate_about_center_unit
// rotates a point counterclockwise about a center by a binary angle
// ----------------------------------------------------------------------------
// Takes one point per clock, unless an output stall has filled the skid
// entry, and returns it rotated about its center. Each input beat is
// answered by exactly one output beat; the depth is set by the angle
// fold (3 stages), a row of six taylor cells (2 stages each, one multiply
// per series per stage), and the rotation (5 stages). Sine and cosine carry
// TRIG_FRAC_BITS fractional bits. A two-entry output register with skid
// keeps s_tready registered, so stalls on the output side stop the
// pipeline without dropping or repeating beats. Results beyond the
// coordinate range saturate and set the clipped flag.
module point_rotate_about_center_unit import prc_pkg::*; #(
  parameter int COORD_WIDTH    = 16,
  parameter int ANGLE_WIDTH    = 16,
  parameter int TRIG_FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // point_x, point_y, center_x, center_y, angle, zero pad
  input  logic [((4*COORD_WIDTH+ANGLE_WIDTH+7)/8)*8-1:0] s_tdata,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // rotated_x, rotated_y, zero pad
  output logic [((2*COORD_WIDTH+7)/8)*8-1:0] m_tdata,
  // clipped
  output logic                 m_tuser
);

`include "point_rotate_about_center_unit_macros.svh"

  localparam int OUT_DW  = ((2*COORD_WIDTH + 7) / 8) * 8;
  localparam int CRD_W   = 4 * COORD_WIDTH;
  localparam int SIDE_W  = CRD_W + 3;
  localparam logic signed [COORD_WIDTH-1:0] COORD_MAX =
    COORD_WIDTH'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
  localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = -COORD_MAX - COORD_WIDTH'(1);

  logic                          en;
  logic                          prep_valid;
  q30_t                          prep_x, prep_x2;
  quad_t                         prep_quad;
  logic                          prep_swap;
  logic [CRD_W-1:0]              prep_side;

  logic                          ch_valid  [0:SERIES_TERMS];
  q30_t                          ch_x2     [0:SERIES_TERMS];
  term_t                         ch_term_s [0:SERIES_TERMS];
  term_t                         ch_term_c [0:SERIES_TERMS];
  sum_t                          ch_sum_s  [0:SERIES_TERMS];
  sum_t                          ch_sum_c  [0:SERIES_TERMS];
  logic [SIDE_W-1:0]             ch_side   [0:SERIES_TERMS];

  logic                          pipe_valid;
  logic signed [COORD_WIDTH-1:0] pipe_x, pipe_y;
  logic                          pipe_clip;

  logic                          skid_valid;
  logic signed [COORD_WIDTH-1:0] skid_x, skid_y, out_x, out_y;
  logic                          skid_clip;

  assign en       = !skid_valid;
  assign s_tready = !skid_valid;

  prc_angle_prep #(
    .ANGLE_WIDTH (ANGLE_WIDTH),
    .SIDE_W      (CRD_W)
  ) u_prep (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_tvalid),
    .angle     (s_tdata[CRD_W +: ANGLE_WIDTH]),
    .side_in   (s_tdata[CRD_W-1:0]),
    .out_valid (prep_valid),
    .x         (prep_x),
    .x2        (prep_x2),
    .quad      (prep_quad),
    .swap      (prep_swap),
    .side_out  (prep_side)
  );

  // first terms: x for sine, one for cosine; sums start empty
  assign ch_valid[0]  = prep_valid;
  assign ch_x2[0]     = prep_x2;
  assign ch_term_s[0] = TERM_W'(prep_x);
  assign ch_term_c[0] = Q30_ONE;
  assign ch_sum_s[0]  = '0;
  assign ch_sum_c[0]  = '0;
  assign ch_side[0]   = {prep_swap, prep_quad, prep_side};

  for (genvar k = 0; k < SERIES_TERMS; k++) begin : g_cell
    prc_series_cell #(
      .DIV_S  ((2*k + 2) * (2*k + 3)),
      .DIV_C  ((2*k + 1) * (2*k + 2)),
      .NEG    (k % 2 == 1),
      .SIDE_W (SIDE_W)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .en         (en),
      .in_valid   (ch_valid[k]),
      .x2_in      (ch_x2[k]),
      .term_s_in  (ch_term_s[k]),
      .term_c_in  (ch_term_c[k]),
      .sum_s_in   (ch_sum_s[k]),
      .sum_c_in   (ch_sum_c[k]),
      .side_in    (ch_side[k]),
      .out_valid  (ch_valid[k+1]),
      .x2_out     (ch_x2[k+1]),
      .term_s_out (ch_term_s[k+1]),
      .term_c_out (ch_term_c[k+1]),
      .sum_s_out  (ch_sum_s[k+1]),
      .sum_c_out  (ch_sum_c[k+1]),
      .side_out   (ch_side[k+1])
    );
  end

  prc_rotate #(
    .COORD_WIDTH    (COORD_WIDTH),
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_rotate (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (ch_valid[SERIES_TERMS]),
    .sum_s     (ch_sum_s[SERIES_TERMS]),
    .sum_c     (ch_sum_c[SERIES_TERMS]),
    .term_s    (ch_term_s[SERIES_TERMS]),
    .term_c    (ch_term_c[SERIES_TERMS]),
    .quad      (ch_side[SERIES_TERMS][CRD_W +: 2]),
    .swap      (ch_side[SERIES_TERMS][CRD_W+2]),
    .px        (ch_side[SERIES_TERMS][0 +: COORD_WIDTH]),
    .py        (ch_side[SERIES_TERMS][COORD_WIDTH +: COORD_WIDTH]),
    .cx        (ch_side[SERIES_TERMS][2*COORD_WIDTH +: COORD_WIDTH]),
    .cy        (ch_side[SERIES_TERMS][3*COORD_WIDTH +: COORD_WIDTH]),
    .out_valid (pipe_valid),
    .rotated_x (pipe_x),
    .rotated_y (pipe_y),
    .clipped   (pipe_clip)
  );

  // output register with skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid   <= skid_valid || pipe_valid;
      skid_valid <= 1'b0;
    end else if (pipe_valid && !skid_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!m_tvalid || m_tready) begin
      out_x   <= skid_valid ? skid_x : pipe_x;
      out_y   <= skid_valid ? skid_y : pipe_y;
      m_tuser <= skid_valid ? skid_clip : pipe_clip;
    end
    if (m_tvalid && !m_tready && !skid_valid) begin
      skid_x    <= pipe_x;
      skid_y    <= pipe_y;
      skid_clip <= pipe_clip;
    end
  end

  assign m_tdata = OUT_DW'({out_y, out_x});

  `PRC_ASSERT_NOW(a_skid_needs_out, skid_valid, m_tvalid, "skid entry held without output beat")
  `PRC_ASSERT_NOW(a_skid_fill_on_stall, $rose(skid_valid), $past(m_tvalid && !m_tready), "skid filled without stall")
  `PRC_ASSERT_NEXT(a_pipe_holds, pipe_valid && skid_valid, pipe_valid && $stable(pipe_x) && $stable(pipe_y), "stalled result changed")
  `PRC_ASSERT_NOW(a_clip_at_bound, m_tvalid && m_tuser, out_x == COORD_MAX || out_x == COORD_MIN || out_y == COORD_MAX || out_y == COORD_MIN, "clipped beat not at a bound")

endmodule
